// ===== hw/rtl/caf_pkg.sv =====
// shared constants, types and saturating helpers for the counting filter
`default_nettype none

package caf_pkg;

    // alphabet and window sizing
    localparam int SYM_W         = 8;
    localparam int ALPHABET_SIZE = 256;
    localparam int HIST_AW       = $clog2(ALPHABET_SIZE);
    localparam int MAX_PATTERN   = 64;
    localparam int PTR_W         = $clog2(MAX_PATTERN);
    localparam int FILL_W        = $clog2(MAX_PATTERN + 1);

    // configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFF       = 1'b1;
    localparam logic [CFG_W-1:0]     RESET_PATTERN_LENGTH = 7'd16;
    localparam logic [CFG_W-1:0]     RESET_MAX_DIFF       = 7'd1;

    // input kinds carried in tuser
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // counters and stream widths
    localparam int IDX_W       = 32;
    localparam int CNT_W       = 8;
    localparam int IN_USER_W   = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
    localparam logic signed [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic signed [CNT_W-1:0] MATCH_RESET =
        CNT_W'(RESET_MAX_DIFF) - CNT_W'(RESET_PATTERN_LENGTH);

    // histogram operation kinds
    typedef enum logic [1:0] {
        OP_ADD,
        OP_RETURN,
        OP_TAKE
    } hop_t;

    // one classified item between the front and the back
    typedef struct packed {
        logic              is_text;
        logic              clear;
        logic              has_old;
        logic              emit;
        logic [SYM_W-1:0]  sym;
        logic [SYM_W-1:0]  old_sym;
        logic [IDX_W-1:0]  pos;
    } caf_item_t;

    // one result
    typedef struct packed {
        logic             candidate;
        logic [IDX_W-1:0] window_end;
    } caf_res_t;

    function automatic logic signed [CNT_W-1:0] sat_inc(input logic signed [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    function automatic logic signed [CNT_W-1:0] sat_dec(input logic signed [CNT_W-1:0] v);
        return (v == CNT_MIN) ? v : v - CNT_ONE;
    endfunction

    function automatic logic is_pos(input logic signed [CNT_W-1:0] v);
        return !v[CNT_W-1] && (v != '0);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/caf_ram.sv =====
// generic simple dual-port ram, registered read, old data on read-during-write
`default_nettype none

module caf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/caf_front.sv =====
// front end: accepts symbols, keeps the window delay line and classifies items
`default_nettype none

module caf_front import caf_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [SYM_W-1:0]     s_tdata,
    input  wire logic [IN_USER_W-1:0] s_tuser,
    input  wire logic [CFG_W-1:0]     pattern_length,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      caf_item_t            out_item
);

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  text_idx_reg, text_idx_next;
    logic              f1_valid_reg, f1_valid_next;
    caf_item_t         f1_item_reg, f1_item_next;

    logic              accept;
    logic              cmd;
    logic              clr;
    logic [CFG_W-1:0]  len_eff;
    logic [PTR_W-1:0]  wp_cur;
    logic [FILL_W-1:0] fill_cur;
    logic [FILL_W-1:0] fill_inc;
    logic [IDX_W-1:0]  idx_cur;
    logic [PTR_W-1:0]  rd_addr;
    logic [SYM_W-1:0]  dl_rdata;

    assign cmd      = s_tuser[0];
    assign clr      = s_tuser[1];
    assign s_tready = !f1_valid_reg || out_ready;
    assign accept   = s_tvalid && s_tready;

    // window length clipped to the supported range
    always_comb begin
        if (pattern_length == '0) begin
            len_eff = CFG_W'(1);
        end else if (pattern_length > CFG_W'(MAX_PATTERN)) begin
            len_eff = CFG_W'(MAX_PATTERN);
        end else begin
            len_eff = pattern_length;
        end
    end

    // state as seen after an optional clear
    assign wp_cur   = clr ? '0 : wr_ptr_reg;
    assign fill_cur = clr ? '0 : fill_reg;
    assign idx_cur  = clr ? '0 : text_idx_reg;
    assign fill_inc = (fill_cur == FILL_W'(MAX_PATTERN)) ? fill_cur : fill_cur + FILL_W'(1);
    assign rd_addr  = wp_cur - len_eff[PTR_W-1:0];

    // next state of window bookkeeping and the classified item
    always_comb begin
        wr_ptr_next   = wr_ptr_reg;
        fill_next     = fill_reg;
        text_idx_next = text_idx_reg;
        f1_item_next  = f1_item_reg;
        f1_valid_next = f1_valid_reg && !out_ready;
        if (accept) begin
            f1_valid_next        = 1'b1;
            f1_item_next.is_text = (cmd == CMD_TEXT);
            f1_item_next.clear   = clr;
            f1_item_next.sym     = s_tdata;
            f1_item_next.old_sym = '0;
            f1_item_next.pos     = idx_cur;
            f1_item_next.has_old = 1'b0;
            f1_item_next.emit    = 1'b0;
            wr_ptr_next          = wp_cur;
            fill_next            = fill_cur;
            text_idx_next        = idx_cur;
            if (cmd == CMD_TEXT) begin
                f1_item_next.has_old = (FILL_W'(fill_cur) >= FILL_W'(len_eff));
                f1_item_next.emit    = (FILL_W'(fill_inc) >= FILL_W'(len_eff));
                wr_ptr_next          = wp_cur + PTR_W'(1);
                fill_next            = fill_inc;
                text_idx_next        = (idx_cur == '1) ? idx_cur : idx_cur + IDX_W'(1);
            end
        end
    end

    // window delay line
    caf_ram #(
        .WIDTH(SYM_W),
        .DEPTH(MAX_PATTERN)
    ) u_delay_line (
        .aclk  (aclk),
        .we    (accept && (cmd == CMD_TEXT)),
        .waddr (wp_cur),
        .wdata (s_tdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (dl_rdata)
    );

    // leaving symbol joins the item as it goes to the queue
    always_comb begin
        out_item         = f1_item_reg;
        out_item.old_sym = dl_rdata;
    end
    assign out_valid = f1_valid_reg;

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            text_idx_reg <= '0;
            f1_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
            text_idx_reg <= text_idx_next;
            f1_valid_reg <= f1_valid_next;
        end
        f1_item_reg <= f1_item_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/caf_queue.sv =====
// short item queue between the front and the back
`default_nettype none

module caf_queue import caf_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push_valid,
    output      logic      push_ready,
    input  wire caf_item_t push_item,
    output      logic      pop_valid,
    input  wire logic      pop,
    output      caf_item_t pop_item
);

    caf_item_t        entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_reg, wr_next;
    logic [Q_AW-1:0]  rd_reg, rd_next;
    logic [Q_AW:0]    cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != (Q_AW+1)'(Q_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = entry_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and occupancy update
    always_comb begin
        wr_next  = do_push ? wr_reg + Q_AW'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + Q_AW'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + (Q_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (do_push) begin
            entry_reg[wr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/caf_back.sv =====
// back end: histogram read-modify-write pipeline, match count and result buffer
`default_nettype none

module caf_back import caf_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    input  wire caf_item_t              in_item,
    output      logic                   in_pop,
    input  wire logic [CFG_W-1:0]       pattern_length,
    input  wire logic [CFG_W-1:0]       max_diff,
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_TDATA_W-1:0] m_tdata
);

    // issue stage
    logic               ph_reg, ph_next;
    hop_t               iss_kind;
    logic [HIST_AW-1:0] iss_addr;
    logic               iss_last;
    logic               iss_emit;
    logic               room;
    logic               issue;

    // histogram stage
    logic               s1_valid_reg;
    hop_t               s1_kind_reg;
    logic [HIST_AW-1:0] s1_addr_reg;
    logic               s1_clear_reg;
    logic               s1_emit_reg;
    logic [IDX_W-1:0]   s1_pos_reg;

    logic               fwd_valid_reg;
    logic [HIST_AW-1:0] fwd_addr_reg;
    logic [CNT_W-1:0]   fwd_data_reg;

    logic [ALPHABET_SIZE-1:0] hvalid_reg, hvalid_next;
    logic signed [CNT_W-1:0]  match_reg, match_next;

    logic [CNT_W-1:0]         h_rdata;
    logic signed [CNT_W-1:0]  h_cur;
    logic signed [CNT_W-1:0]  h_new;
    logic signed [CNT_W-1:0]  base;
    logic signed [CNT_W-1:0]  thr;

    // result buffer
    caf_res_t    ob_reg [2];
    logic        ob_wr_reg, ob_rd_reg;
    logic [1:0]  ob_cnt_reg, ob_cnt_next;
    logic        ob_push;
    logic        ob_pop;

    // pick the next histogram operation of the head item
    always_comb begin
        if (in_item.is_text && in_item.has_old && !ph_reg) begin
            iss_kind = OP_RETURN;
            iss_addr = in_item.old_sym[HIST_AW-1:0];
            iss_last = 1'b0;
        end else begin
            iss_kind = in_item.is_text ? OP_TAKE : OP_ADD;
            iss_addr = in_item.sym[HIST_AW-1:0];
            iss_last = 1'b1;
        end
    end

    assign iss_emit = iss_last && in_item.is_text && in_item.emit;
    assign room     = ({1'b0, ob_cnt_reg} + {2'b00, s1_valid_reg && s1_emit_reg}) < 3'd2;
    assign issue    = in_valid && (!iss_emit || room);
    assign in_pop   = issue && iss_last;
    assign ph_next  = issue ? !iss_last : ph_reg;

    // histogram memory
    caf_ram #(
        .WIDTH(CNT_W),
        .DEPTH(ALPHABET_SIZE)
    ) u_histogram (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (h_new),
        .re    (issue),
        .raddr (iss_addr),
        .rdata (h_rdata)
    );

    assign thr = CNT_W'(max_diff) - CNT_W'(pattern_length);

    // current entry value: cleared, forwarded from last write, stored or never written
    always_comb begin
        if (s1_clear_reg) begin
            h_cur = '0;
        end else if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) begin
            h_cur = fwd_data_reg;
        end else if (hvalid_reg[s1_addr_reg]) begin
            h_cur = h_rdata;
        end else begin
            h_cur = '0;
        end
        base = s1_clear_reg ? thr : match_reg;
    end

    // credit update and match count
    always_comb begin
        case (s1_kind_reg)
            OP_RETURN: begin
                h_new      = sat_inc(h_cur);
                match_next = is_pos(h_new) ? sat_dec(base) : base;
            end
            OP_TAKE: begin
                h_new      = sat_dec(h_cur);
                match_next = is_pos(h_cur) ? sat_inc(base) : base;
            end
            default: begin
                h_new      = sat_inc(h_cur);
                match_next = base;
            end
        endcase
    end

    // written-entry flags, all dropped on a clear
    always_comb begin
        hvalid_next = hvalid_reg;
        if (s1_valid_reg) begin
            if (s1_clear_reg) begin
                hvalid_next = '0;
            end
            hvalid_next[s1_addr_reg] = 1'b1;
        end
    end

    // result buffer control
    assign ob_push  = s1_valid_reg && s1_emit_reg;
    assign ob_pop   = m_tvalid && m_tready;
    assign m_tvalid = (ob_cnt_reg != 2'd0);
    assign m_tdata  = {{(OUT_TDATA_W-IDX_W-1){1'b0}},
                       ob_reg[ob_rd_reg].window_end, ob_reg[ob_rd_reg].candidate};

    always_comb begin
        ob_cnt_next = ob_cnt_reg;
        if (ob_push && !ob_pop) begin
            ob_cnt_next = ob_cnt_reg + 2'd1;
        end else if (ob_pop && !ob_push) begin
            ob_cnt_next = ob_cnt_reg - 2'd1;
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg        <= 1'b0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            hvalid_reg    <= '0;
            match_reg     <= MATCH_RESET;
            ob_wr_reg     <= 1'b0;
            ob_rd_reg     <= 1'b0;
            ob_cnt_reg    <= 2'd0;
        end else begin
            ph_reg        <= ph_next;
            s1_valid_reg  <= issue;
            fwd_valid_reg <= s1_valid_reg;
            hvalid_reg    <= hvalid_next;
            if (s1_valid_reg) begin
                match_reg <= match_next;
            end
            if (ob_push) begin
                ob_wr_reg <= !ob_wr_reg;
            end
            if (ob_pop) begin
                ob_rd_reg <= !ob_rd_reg;
            end
            ob_cnt_reg <= ob_cnt_next;
        end
        if (issue) begin
            s1_kind_reg  <= iss_kind;
            s1_addr_reg  <= iss_addr;
            s1_clear_reg <= in_item.clear && iss_last;
            s1_emit_reg  <= iss_emit;
            s1_pos_reg   <= in_item.pos;
        end
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= h_new;
        if (ob_push) begin
            ob_reg[ob_wr_reg].candidate  <= !match_next[CNT_W-1];
            ob_reg[ob_wr_reg].window_end <= s1_pos_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/counting_filter_approx_match.sv =====
// Counting filter for approximate matching: top level with configuration registers.
// Throughput: one pattern symbol per cycle unless text ahead stalls; a text symbol with a full
// window issues a return and then a take on the single read port of the histogram memory.
// Path to a result: front item register, item queue, histogram stage, result buffer.
// Reset (aresetn low, synchronous): pattern_length 16, max_diff 1, histogram and
// window empty, match count -15, text index 0; no result pending after reset.
`default_nettype none

module counting_filter_approx_match import caf_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input stream
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [SYM_W-1:0]       s_tdata,   // [7:0] symbol
    input  wire logic [IN_USER_W-1:0]   s_tuser,   // [0] command, [1] new_pattern
    // result stream
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_TDATA_W-1:0] m_tdata,   // [0] candidate, [32:1] window_end, zeros
    // configuration writes
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    logic [CFG_W-1:0] pattern_length_reg;
    logic [CFG_W-1:0] max_diff_reg;

    logic      q_push_valid;
    logic      q_push_ready;
    caf_item_t q_push_item;
    logic      q_pop_valid;
    logic      q_pop;
    caf_item_t q_pop_item;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= RESET_PATTERN_LENGTH;
            max_diff_reg       <= RESET_MAX_DIFF;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data;
                REG_MAX_DIFF:       max_diff_reg       <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front end
    caf_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .pattern_length (pattern_length_reg),
        .out_valid      (q_push_valid),
        .out_ready      (q_push_ready),
        .out_item       (q_push_item)
    );

    // decoupling queue
    caf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop        (q_pop),
        .pop_item   (q_pop_item)
    );

    // back end
    caf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (q_pop_valid),
        .in_item        (q_pop_item),
        .in_pop         (q_pop),
        .pattern_length (pattern_length_reg),
        .max_diff       (max_diff_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/caf_checker.sv =====
// port-level checks for the counting filter, bound to the top level
`default_nettype none

module caf_checker import caf_pkg::*; (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic                   cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // padding above window_end stays zero
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_TDATA_W-1:IDX_W+1] == '0))
        else $error("result padding not zero");

    // reset drops any pending result
    a_reset_flush: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // both inputs ready right after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> s_tready && cfg_ready)
        else $error("not ready after reset");

endmodule

bind counting_filter_approx_match caf_checker u_caf_checker (.*);

`default_nettype wire

// ===== sim/counting_filter_approx_match_tb.sv =====
// self-checking testbench for the k-differences counting filter with a scoreboard class
`default_nettype none

module counting_filter_approx_match_tb;
    import caf_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1700;
    localparam int CALM_FROM   = 1450;

    // scoreboard: its own copy of the filter state and the expected results
    class filter_scoreboard;
        logic signed [CNT_W-1:0] hist [ALPHABET_SIZE];
        logic [SYM_W-1:0]        window [MAX_PATTERN];
        logic signed [CNT_W-1:0] match_cnt;
        logic [IDX_W-1:0]        next_index;
        int unsigned             wr_ptr;
        int unsigned             fill;
        logic [CFG_W-1:0]        pat_len;
        logic [CFG_W-1:0]        diff_allowed;
        caf_res_t                pending[$];
        int                      errors;

        function new();
            errors = 0;
            pat_len = RESET_PATTERN_LENGTH;
            diff_allowed = RESET_MAX_DIFF;
            foreach (window[i]) window[i] = '0;
            clear_filter();
        endfunction

        function logic signed [CNT_W-1:0] clamp(int v);
            if (v > 127) return CNT_MAX;
            if (v < -128) return CNT_MIN;
            return CNT_W'(v);
        endfunction

        // threshold is taken from the registers only here
        function void clear_filter();
            foreach (hist[i]) hist[i] = '0;
            wr_ptr = 0;
            fill = 0;
            next_index = '0;
            match_cnt = clamp(int'(diff_allowed) - int'(pat_len));
        endfunction

        function int window_len();
            if (pat_len < 1) return 1;
            if (pat_len > MAX_PATTERN) return MAX_PATTERN;
            return int'(pat_len);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_PATTERN_LENGTH) pat_len = val;
            else diff_allowed = val;
        endfunction

        // advance the filter by one accepted symbol
        function void note_symbol(logic cmd, logic [SYM_W-1:0] sym, logic np);
            int len;
            int h;
            int unsigned rd;
            logic [SYM_W-1:0] leaving;
            caf_res_t res;
            if (np) clear_filter();
            if (cmd == CMD_PATTERN) begin
                h = hist[sym];
                hist[sym] = clamp(h + 1);
                return;
            end
            len = window_len();
            // symbol leaving the window gives its credit back
            if (fill >= len) begin
                rd = (wr_ptr + MAX_PATTERN - len) % MAX_PATTERN;
                leaving = window[PTR_W'(rd)];
                h = hist[leaving];
                hist[leaving] = clamp(h + 1);
                if (hist[leaving] > 0) match_cnt = clamp(int'(match_cnt) - 1);
            end
            // entering symbol takes a credit
            h = hist[sym];
            if (h > 0) match_cnt = clamp(int'(match_cnt) + 1);
            hist[sym] = clamp(h - 1);
            window[PTR_W'(wr_ptr)] = sym;
            wr_ptr = (wr_ptr + 1) % MAX_PATTERN;
            if (fill < MAX_PATTERN) fill++;
            res.window_end = next_index;
            if (next_index != '1) next_index++;
            if (fill >= len) begin
                res.candidate = !match_cnt[CNT_W-1];
                pending.push_back(res);
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(caf_res_t got);
            caf_res_t want;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing expected (candidate %0b end %0d)",
                                 got.candidate, got.window_end));
                return;
            end
            want = pending.pop_front();
            if (got.candidate !== want.candidate)
                report($sformatf("candidate %0b, expected %0b at window end %0d",
                                 got.candidate, want.candidate, want.window_end));
            if (got.window_end !== want.window_end)
                report($sformatf("window end %0d, expected %0d",
                                 got.window_end, want.window_end));
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SYM_W-1:0]       s_tdata = '0;     // [7:0] symbol
    logic [IN_USER_W-1:0]   s_tuser = '0;     // [0] command, [1] new_pattern
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [0] candidate, [32:1] window_end
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    filter_scoreboard sb = new();
    int items_sent = 0;
    bit calm = 1'b0;
    int send_idle_pct = 20;
    int recv_idle_pct = 20;
    int stall_left = 0;
    int cycle_count = 0;

    counting_filter_approx_match DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side back-pressure in bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(1, 100) <= recv_idle_pct) begin
            m_tready = 1'b0;
            stall_left = $urandom_range(0, 5);
        end else begin
            m_tready = 1'b1;
        end
    end

    // result transfers
    always @(posedge aclk) begin
        caf_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.candidate = m_tdata[0];
            got.window_end = m_tdata[IDX_W:1];
            sb.check_result(got);
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // one input transfer, entered and left at a falling edge
    task automatic send_item(input logic cmd, input logic [SYM_W-1:0] sym, input logic np);
        if (!calm && $urandom_range(1, 100) <= send_idle_pct)
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = sym;
        s_tuser = {np, cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_symbol(cmd, sym, np);
        items_sent++;
        if (items_sent >= CALM_FROM) calm = 1'b1;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // hold the sender until every result is out and the pipeline has settled
    task automatic wait_drained();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // one pattern followed by a stretch of text, with some noise
    task automatic run_phase(input int phase_no);
        int m;
        int k;
        int eff;
        int span;
        int mode;
        int n_text;
        int done;
        int r;
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] pat [MAX_PATTERN];
        logic [SYM_W-1:0] sym;
        wait_drained();
        send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
        recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);

        // register settings, mostly short windows
        case ($urandom_range(0, 11))
            0: m = $urandom_range(0, 1) ? 0 : 127;
            1: m = $urandom_range(65, 127);
            2: m = MAX_PATTERN;
            default: m = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 7))
            0: k = $urandom_range(0, 127);
            1: k = 0;
            default: k = $urandom_range(0, (m < 3) ? m : 3);
        endcase
        if (phase_no == 2) begin
            m = 4;
            k = 0;
        end
        r = $urandom_range(0, 3);
        if (r != 1) write_reg(REG_PATTERN_LENGTH, CFG_W'(m));
        if (r != 2) write_reg(REG_MAX_DIFF, CFG_W'(k));
        eff = sb.window_len();

        // histogram counter saturation: one symbol repeated past the top
        if (phase_no == 2) begin
            for (int i = 0; i < 140; i++) send_item(CMD_PATTERN, 8'h5A, i == 0);
            for (int i = 0; i < 10; i++) send_item(CMD_TEXT, 8'h5A, 1'b0);
            return;
        end

        base = SYM_W'($urandom_range(0, 255));
        span = $urandom_range(1, 8);
        foreach (pat[i]) pat[i] = base + SYM_W'($urandom_range(0, span - 1));
        mode = $urandom_range(0, 19);

        // pattern: normally opened with a clear, sometimes continued or skipped
        if (mode != 1)
            for (int i = 0; i < eff; i++)
                send_item(CMD_PATTERN, pat[PTR_W'(i)], (mode != 0) && (i == 0));

        // text
        n_text = eff + $urandom_range(0, 2 * eff + 8);
        done = 0;
        while (done < n_text) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                send_item(CMD_TEXT, SYM_W'($urandom_range(0, 255)), (mode == 1) && (done == 0));
                done++;
            end else if (r == 1 && done > 0) begin
                send_item(CMD_PATTERN, pat[PTR_W'($urandom_range(0, eff - 1))], 1'b0);
            end else if (r <= 5) begin
                // a copy of the pattern, at times with substitutions
                for (int j = 0; j < eff; j++) begin
                    sym = pat[PTR_W'(j)];
                    if ($urandom_range(0, eff) == 0)
                        sym = base + SYM_W'($urandom_range(0, span));
                    send_item(CMD_TEXT, sym, (mode == 1) && (done == 0));
                    done++;
                end
            end else begin
                send_item(CMD_TEXT, base + SYM_W'($urandom_range(0, span)),
                          (mode == 1) && (done == 0));
                done++;
            end
        end
    endtask

    // stimulus
    initial begin
        int phase_no;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: two-symbol window, exact match
        write_reg(REG_PATTERN_LENGTH, 7'd2);
        write_reg(REG_MAX_DIFF, 7'd0);
        send_item(CMD_PATTERN, 8'h00, 1'b1);
        send_item(CMD_PATTERN, 8'hFF, 1'b0);
        send_item(CMD_TEXT, 8'h00, 1'b0);
        send_item(CMD_TEXT, 8'hFF, 1'b0);
        send_item(CMD_TEXT, 8'h00, 1'b0);
        // pattern symbol arriving after text
        send_item(CMD_PATTERN, 8'h00, 1'b0);
        send_item(CMD_TEXT, 8'h00, 1'b0);
        // clear carried on a text symbol
        send_item(CMD_TEXT, 8'hAA, 1'b1);
        send_item(CMD_TEXT, 8'h55, 1'b0);
        send_item(CMD_TEXT, 8'h55, 1'b0);

        // zero length acts as one; threshold clamps at the top
        wait_drained();
        write_reg(REG_PATTERN_LENGTH, 7'd0);
        write_reg(REG_MAX_DIFF, 7'd127);
        send_item(CMD_PATTERN, 8'h01, 1'b1);
        send_item(CMD_TEXT, 8'h01, 1'b0);
        send_item(CMD_TEXT, 8'h02, 1'b0);

        // oversized length acts as the maximum; lowest threshold
        wait_drained();
        write_reg(REG_PATTERN_LENGTH, 7'd127);
        write_reg(REG_MAX_DIFF, 7'd0);
        send_item(CMD_PATTERN, 8'h03, 1'b1);
        send_item(CMD_TEXT, 8'h03, 1'b0);
        send_item(CMD_TEXT, 8'h80, 1'b0);

        // random phases until the item budget is spent
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            run_phase(phase_no);
            phase_no++;
        end

        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
